// File: rtl/dsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg
// shared types and constants of the discord search block
// ----------------------------------------------------------------------------
package dsc_pkg;

	// width and saturation limit of a squared distance
	localparam int DIST_W = 48;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// window length register
	localparam int WL_W = 9;
	localparam logic [WL_W-1:0] WL_RESET = 9'd16;
	localparam int WIN_MIN = 2;

	// one term of a pair sum entering the shared unit
	typedef struct packed {
		logic valid;
		logic last;
	} mac_ctl_t;

	// pair result leaving the shared unit
	typedef struct packed {
		logic              done;
		logic [DIST_W-1:0] sum;
	} mac_res_t;

endpackage

// File: rtl/dsc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_store
// sample memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module dsc_store #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [DATA_W-1:0]        rd_data_a,
	output logic [DATA_W-1:0]        rd_data_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// File: rtl/dsc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_mac
// shared difference, square and saturating accumulate unit
// ----------------------------------------------------------------------------
module dsc_mac #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dsc_pkg::mac_ctl_t               ctl,
	input  logic signed [SAMPLE_BITS-1:0]   a_s1,
	input  logic signed [SAMPLE_BITS-1:0]   b_s1,
	input  logic [dsc_pkg::DIST_W-1:0]      limit,
	output dsc_pkg::mac_res_t               res
);
	import dsc_pkg::*;

	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W  = ((PROD_W > DIST_W) ? PROD_W : DIST_W) + 1;

	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        mag;
	logic [PROD_W-1:0]        prod_s2;
	logic                     valid_s2;
	logic                     last_s2;
	logic [DIST_W-1:0]        acc_q;
	logic [SUM_W-1:0]         sum_wide;
	logic [DIST_W-1:0]        sum_sat;

	always_comb begin
		diff = DIFF_W'(a_s1) - DIFF_W'(b_s1);
		mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	end

	always_comb begin
		sum_wide = SUM_W'(acc_q) + SUM_W'(prod_s2);
		sum_sat  = (sum_wide > SUM_W'(DIST_MAX)) ? DIST_MAX : sum_wide[DIST_W-1:0];
		// pair ends at its last term or once the sum cannot beat the limit
		res.done = valid_s2 && (last_s2 || (sum_sat >= limit));
		res.sum  = sum_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (res.done) begin
				valid_s2 <= 1'b0;
				acc_q    <= '0;
			end else begin
				valid_s2 <= ctl.valid;
				if (valid_s2) begin
					acc_q <= sum_sat;
				end
			end
			last_s2 <= ctl.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(mag) * PROD_W'(mag);
	end

endmodule

// File: rtl/time_series_discord_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_series_discord_search_top
// brute-force discord search over a loaded, already normalised series
// ----------------------------------------------------------------------------
// Samples are loaded one per cycle into an internal store; a transfer with
// last_sample set ends the series and starts the search, during which
// sample_stall is high. For each start i the block measures the squared
// distance to every start j at least one window away, one sample pair per
// cycle through a single difference-square-accumulate unit fed by the two
// read ports of the store, and keeps the nearest; the start whose nearest
// distance is largest wins, first index on ties. A pair sums up to
// window_length terms, so a search measures at most starts * starts
// pairs with starts = count - window_length + 1; the pair sum stops
// as soon as it reaches the current nearest distance, and a start stops
// once its nearest falls to the best so far, which usually cuts this work
// by a large factor. The result sits in an output register; the search
// hands it over once a previous result has been taken, and loading then
// begins whether or not the new result has been taken. window_length is
// clamped to 2 .. MAX_WINDOW; a series shorter than one window gives start 0
// and distance 0; samples beyond MAX_SERIES_LEN are dropped. No clearing
// pass follows reset.
// ----------------------------------------------------------------------------
module time_series_discord_search_top #(
	parameter int MAX_SERIES_LEN = 1024,
	parameter int MAX_WINDOW     = 256,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dsc_pkg::WL_W-1:0]            window_length,
	// sample channel
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic                                last_sample,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [$clog2(MAX_SERIES_LEN)-1:0]   discord_start,
	output logic [dsc_pkg::DIST_W-1:0]          nearest_distance
);
	import dsc_pkg::*;

	localparam int ADDR_W = $clog2(MAX_SERIES_LEN);
	localparam int CNT_W  = $clog2(MAX_SERIES_LEN + 1);
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W  = $clog2(MAX_SERIES_LEN + MAX_WINDOW + 1);

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_PAIR  = 7'b0000100,
		ST_ISSUE = 7'b0001000,
		ST_WAIT  = 7'b0010000,
		ST_NEXT  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [WL_W-1:0]   wl_q;
	logic [CNT_W-1:0]  count_q;
	logic [WIN_W-1:0]  n_q;
	logic [WIN_W-1:0]  n_clamp;
	logic [WIN_W-1:0]  k_q;
	logic [IDX_W-1:0]  starts_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  i_plus_n;
	logic [IDX_W-1:0]  j_plus_n;
	logic [IDX_W-1:0]  i_next;
	logic [ADDR_W-1:0] a_q;
	logic [ADDR_W-1:0] b_q;
	logic [DIST_W-1:0] nearest_q;
	logic [DIST_W-1:0] best_q;
	logic [ADDR_W-1:0] best_start_q;
	logic              res_valid_q;
	logic [ADDR_W-1:0] res_start_q;
	logic [DIST_W-1:0] res_dist_q;
	logic              term_valid_s1;
	logic              term_last_s1;
	logic              sample_xfer;
	logic              store_wr;
	logic              issue;
	logic              issue_last;
	logic              self_match;
	logic              out_load;
	logic [SAMPLE_BITS-1:0] rd_a;
	logic [SAMPLE_BITS-1:0] rd_b;
	mac_ctl_t          mac_ctl;
	mac_res_t          mac_res;

	// handshakes
	assign cfg_ready    = 1'b1;
	assign sample_stall = (state_q != ST_LOAD);
	assign sample_xfer  = sample_valid && !sample_stall;
	assign store_wr     = sample_xfer && (count_q < CNT_W'(MAX_SERIES_LEN));

	// window length held within its legal range
	always_comb begin
		if (32'(wl_q) < WIN_MIN) begin
			n_clamp = WIN_W'(WIN_MIN);
		end else if (32'(wl_q) > MAX_WINDOW) begin
			n_clamp = WIN_W'(MAX_WINDOW);
		end else begin
			n_clamp = WIN_W'(wl_q);
		end
	end

	// self-match test and index arithmetic
	always_comb begin
		i_plus_n   = i_q + IDX_W'(n_q);
		j_plus_n   = j_q + IDX_W'(n_q);
		i_next     = i_q + IDX_W'(1);
		self_match = (j_plus_n > i_q) && (j_q < i_plus_n);
		issue      = (state_q == ST_ISSUE) && !mac_res.done;
		issue_last = (k_q == n_q - WIN_W'(1));
		out_load   = (state_q == ST_OUT) && (!res_valid_q || !result_stall);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			wl_q <= window_length;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			count_q       <= '0;
			n_q           <= WIN_W'(WIN_MIN);
			k_q           <= '0;
			starts_q      <= '0;
			i_q           <= '0;
			j_q           <= '0;
			a_q           <= '0;
			b_q           <= '0;
			nearest_q     <= DIST_MAX;
			best_q        <= '0;
			best_start_q  <= '0;
			term_valid_s1 <= 1'b0;
			term_last_s1  <= 1'b0;
		end else begin
			term_valid_s1 <= issue;
			term_last_s1  <= issue && issue_last;
			unique case (state_q)
				ST_LOAD: begin
					if (store_wr) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (sample_xfer && last_sample) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					n_q          <= n_clamp;
					best_q       <= '0;
					best_start_q <= '0;
					nearest_q    <= DIST_MAX;
					i_q          <= '0;
					j_q          <= '0;
					starts_q     <= IDX_W'(count_q) - IDX_W'(n_clamp) + IDX_W'(1);
					// short series: straight to the result
					if (IDX_W'(count_q) < IDX_W'(n_clamp)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PAIR;
					end
				end
				ST_PAIR: begin
					// start already lost, or all partners seen
					if ((nearest_q <= best_q) || (j_q >= starts_q)) begin
						state_q <= ST_NEXT;
					end else if (self_match) begin
						j_q <= i_plus_n;
					end else begin
						a_q     <= i_q[ADDR_W-1:0];
						b_q     <= j_q[ADDR_W-1:0];
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (mac_res.done) begin
						if (mac_res.sum < nearest_q) begin
							nearest_q <= mac_res.sum;
						end
						j_q     <= j_q + IDX_W'(1);
						state_q <= ST_PAIR;
					end else begin
						a_q <= a_q + ADDR_W'(1);
						b_q <= b_q + ADDR_W'(1);
						k_q <= k_q + WIN_W'(1);
						if (issue_last) begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (mac_res.done) begin
						if (mac_res.sum < nearest_q) begin
							nearest_q <= mac_res.sum;
						end
						j_q     <= j_q + IDX_W'(1);
						state_q <= ST_PAIR;
					end
				end
				ST_NEXT: begin
					// a lost start always has nearest at or below best
					if (nearest_q > best_q) begin
						best_q       <= nearest_q;
						best_start_q <= i_q[ADDR_W-1:0];
					end
					nearest_q <= DIST_MAX;
					i_q       <= i_next;
					j_q       <= '0;
					if (i_next >= starts_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PAIR;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						count_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result register, parts the search from the downstream stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_start_q <= '0;
			res_dist_q  <= '0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
			res_start_q <= best_start_q;
			res_dist_q  <= best_q;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid     = res_valid_q;
	assign discord_start    = res_start_q;
	assign nearest_distance = res_dist_q;

	dsc_store #(
		.DEPTH  (MAX_SERIES_LEN),
		.DATA_W (SAMPLE_BITS)
	) u_store (
		.clk       (clk),
		.wr_en     (store_wr),
		.wr_addr   (count_q[ADDR_W-1:0]),
		.wr_data   (sample),
		.rd_en     (issue),
		.rd_addr_a (a_q),
		.rd_addr_b (b_q),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	assign mac_ctl.valid = term_valid_s1;
	assign mac_ctl.last  = term_last_s1;

	dsc_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a_s1   (signed'(rd_a)),
		.b_s1   (signed'(rd_b)),
		.limit  (nearest_q),
		.res    (mac_res)
	);

`ifndef ASSERT_OFF
	// a pair can only complete while the sequencer waits on it
	a_done_in_pair: assert property (@(posedge clk) disable iff (!arst_n)
		mac_res.done |-> ((state_q == ST_ISSUE) || (state_q == ST_WAIT)))
		else $error("pair completion outside pair states");

	// a new result only ever comes from the output step
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside output step");

	// nearest distance of a start only shrinks
	a_nearest_falls: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != ST_START) && (state_q != ST_NEXT)) |=>
		(nearest_q <= $past(nearest_q)))
		else $error("nearest distance grew within a start");

	// best distance only grows during a search
	a_best_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_START) |=> (best_q >= $past(best_q)))
		else $error("best distance fell during search");
`endif

endmodule
